FILE: hw/rtl/wtor_pkg.sv
// Shared types, constants and helper functions of the wavetable oscillator.
// No dependencies; imported by the top level, wtor_ctrl and wtor_scale.
`timescale 1ns / 1ps
`default_nettype none

package wtor_pkg;

	localparam int TABLE_DEPTH     = 1024;
	localparam int SAMPLE_WIDTH    = 16;
	localparam int PHASE_FRAC_BITS = 16;

	localparam int TBL_AW   = $clog2(TABLE_DEPTH);
	localparam int PHASE_W  = 26;
	localparam int AMP_W    = 16;
	localparam int SIZE_W   = 11;
	localparam int ENTRY_W  = 16;
	localparam int PROD_W   = ENTRY_W + AMP_W + 1;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 26;
	localparam int AMP_FRAC = 15;

	localparam logic [AMP_W-1:0] UNITY_AMP = AMP_W'(32768);

	// Input item kinds.
	localparam logic [1:0] FUNC_WRITE   = 2'd0;
	localparam logic [1:0] FUNC_TICK    = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] REG_PHASE_INC   = 3'd0;
	localparam logic [CFG_AW-1:0] REG_TABLE_SIZE  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_TARGET_AMP  = 3'd2;
	localparam logic [CFG_AW-1:0] REG_MUTE        = 3'd3;
	localparam logic [CFG_AW-1:0] REG_RAMP_STEP   = 3'd4;
	localparam logic [CFG_AW-1:0] REG_RIGHT_START = 3'd5;

	// Per-item read request from the control unit to the table pipeline.
	typedef struct packed {
		logic [TBL_AW-1:0] addr_l;
		logic [TBL_AW-1:0] addr_r;
		logic [AMP_W-1:0]  amp;
	} rd_req_t;

	// Floor of product / 2^15, clamped to the signed sample range.
	function automatic logic [SAMPLE_WIDTH-1:0] sat_sample(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-AMP_FRAC-1:0] sh;
		logic signed [PROD_W-AMP_FRAC-1:0] hi;
		logic signed [PROD_W-AMP_FRAC-1:0] lo;
		sh = p[PROD_W-1:AMP_FRAC];
		hi = (PROD_W-AMP_FRAC)'((1 << (SAMPLE_WIDTH-1)) - 1);
		lo = -hi - 2'sd1;
		if (sh > hi) begin
			sat_sample = hi[SAMPLE_WIDTH-1:0];
		end else if (sh < lo) begin
			sat_sample = lo[SAMPLE_WIDTH-1:0];
		end else begin
			sat_sample = sh[SAMPLE_WIDTH-1:0];
		end
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wavetable_oscillator_ramp_core.sv
// Top level of the stereo wavetable oscillator with amplitude ramp.
// Depends on wtor_pkg, wtor_ram, wtor_ctrl and wtor_scale.
//
// Usage: every input item on the s_ channel is one command, chosen by s_tuser.
// A table write stores one signed word, a tick produces one stereo frame, and
// a restart reloads both phases. Every item, whatever its kind, returns exactly
// one item on the m_ channel, in order. For a tick the result carries the two
// scaled samples and m_tuser is high; for any other command the samples are
// zero and m_tuser is low. The amplitude field always shows the amplitude
// after the command.
// Throughput is one item per clock while m_tready stays high. There are three
// register stages: the table read, the two multipliers and the output
// register. The accept edge loads the first one, and m_tvalid rises once an
// item has passed the multiplier stage into the output register. The table
// lives in two copies of a 1024-entry RAM so both channels read in the same
// cycle; a write followed at once by a tick sees the new word.
// Reset clears the phases, the amplitude and the pipeline and loads the
// register defaults; the table is undefined until written. When the receiver
// stalls, stages keep filling until the pipeline is full, and only then does
// s_tready fall. Configuration writes belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none

module wavetable_oscillator_ramp_core
	import wtor_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire logic [31:0]       s_tdata,  // table_index[9:0], table_value[25:10], zero pad
	input  wire logic [1:0]        s_tuser,  // func[1:0]
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	output      logic [47:0]       m_tdata,  // left_sample[15:0], right_sample[31:16],
	                                         // current_amp[47:32]
	output      logic              m_tuser   // sample_valid
);

	logic    accept;
	rd_req_t req;

	// Each stage moves when the stage after it is empty or moving.
	logic out_en;
	logic s2_en;
	logic s1_en;

	logic             v_s1, tick_s1;
	logic [AMP_W-1:0] amp_s1;
	logic             v_s2, tick_s2;
	logic [AMP_W-1:0] amp_s2;

	logic [ENTRY_W-1:0]       entry_l_s1, entry_r_s1;
	logic signed [PROD_W-1:0] prod_l_s2, prod_r_s2;

	logic                    out_v_q;
	logic                    flag_q;
	logic [SAMPLE_WIDTH-1:0] left_q, right_q;
	logic [AMP_W-1:0]        amp_out_q;

	assign out_en   = !out_v_q || m_tready;
	assign s2_en    = !v_s2 || out_en;
	assign s1_en    = !v_s1 || s2_en;
	assign s_tready = s1_en;
	assign accept   = s_tvalid && s_tready;

	wtor_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.func      (s_tuser),
		.req       (req)
	);

	// Both copies take every table write so they stay identical.
	wtor_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram_l (
		.clk   (clk),
		.we    (accept && s_tuser == FUNC_WRITE),
		.waddr (s_tdata[TBL_AW-1:0]),
		.wdata (s_tdata[25:10]),
		.re    (s1_en),
		.raddr (req.addr_l),
		.rdata (entry_l_s1)
	);

	wtor_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram_r (
		.clk   (clk),
		.we    (accept && s_tuser == FUNC_WRITE),
		.waddr (s_tdata[TBL_AW-1:0]),
		.wdata (s_tdata[25:10]),
		.re    (s1_en),
		.raddr (req.addr_r),
		.rdata (entry_r_s1)
	);

	wtor_scale u_scale_l (
		.clk     (clk),
		.en      (s2_en),
		.entry   (entry_l_s1),
		.amp     (amp_s1),
		.prod_s2 (prod_l_s2)
	);

	wtor_scale u_scale_r (
		.clk     (clk),
		.en      (s2_en),
		.entry   (entry_r_s1),
		.amp     (amp_s1),
		.prod_s2 (prod_r_s2)
	);

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_en) begin
				v_s1 <= accept;
			end
			if (s2_en) begin
				v_s2 <= v_s1;
			end
			if (out_en) begin
				out_v_q <= v_s2;
			end
		end
	end

	// Payload side of the pipeline.
	always_ff @(posedge clk) begin
		if (s1_en) begin
			tick_s1 <= (s_tuser == FUNC_TICK);
			amp_s1  <= req.amp;
		end
		if (s2_en) begin
			tick_s2 <= tick_s1;
			amp_s2  <= amp_s1;
		end
		if (out_en) begin
			flag_q    <= tick_s2;
			amp_out_q <= amp_s2;
			left_q    <= tick_s2 ? sat_sample(prod_l_s2) : '0;
			right_q   <= tick_s2 ? sat_sample(prod_r_s2) : '0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = flag_q;
	assign m_tdata  = {amp_out_q, right_q, left_q};

	// Input only stalls when every stage holds an item.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && out_v_q))
		else $error("input stalled with room in the pipeline");

	// Non-tick results carry silent samples.
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:0] == '0)
		else $error("sample data on a non-tick item");

	// A result stalled by the receiver keeps its place at the output.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/wtor_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wtor_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/wtor_ctrl.sv
// Configuration registers, channel phases and the amplitude ramp.
// Depends on wtor_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtor_ctrl
	import wtor_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	input  wire logic              accept,
	input  wire logic [1:0]        func,
	output      rd_req_t           req
);

	logic [PHASE_W-1:0] inc_q;
	logic [SIZE_W-1:0]  size_q;
	logic [AMP_W-1:0]   target_q;
	logic               mute_q;
	logic [AMP_W-1:0]   step_q;
	logic [PHASE_W-1:0] rstart_q;

	logic [PHASE_W-1:0] lph_q;
	logic [PHASE_W-1:0] rph_q;
	logic [AMP_W-1:0]   amp_q;

	logic [AMP_W-1:0]          tgt;
	logic [AMP_W:0]            up_sum;
	logic [AMP_W-1:0]          amp_up;
	logic [AMP_W-1:0]          amp_dn;
	logic [AMP_W-1:0]          amp_tick;
	logic [SIZE_W-1:0]         size_c;
	logic [SIZE_W+PHASE_FRAC_BITS-1:0] wrap;
	logic [PHASE_W-1:0]        lph_nx;
	logic [PHASE_W-1:0]        rph_nx;

	// One phase step with a single conditional wrap.
	function automatic logic [PHASE_W-1:0] advance(
		input logic [PHASE_W-1:0] ph,
		input logic [PHASE_W-1:0] inc,
		input logic [SIZE_W+PHASE_FRAC_BITS-1:0] w
	);
		logic [SIZE_W+PHASE_FRAC_BITS-1:0] p;
		p = (SIZE_W+PHASE_FRAC_BITS)'(ph) + (SIZE_W+PHASE_FRAC_BITS)'(inc);
		if (p >= w) begin
			p = p - w;
		end
		advance = p[PHASE_W-1:0];
	endfunction

	always_comb begin
		tgt      = (target_q > UNITY_AMP) ? UNITY_AMP : target_q;
		up_sum   = {1'b0, amp_q} + {1'b0, step_q};
		amp_up   = (up_sum <= {1'b0, tgt}) ? up_sum[AMP_W-1:0] : tgt;
		amp_dn   = (amp_q >= step_q) ? (amp_q - step_q) : '0;
		amp_tick = mute_q ? amp_dn : amp_up;

		if (size_q == '0) begin
			size_c = SIZE_W'(1);
		end else if (size_q > SIZE_W'(TABLE_DEPTH)) begin
			size_c = SIZE_W'(TABLE_DEPTH);
		end else begin
			size_c = size_q;
		end
		wrap   = {size_c, {PHASE_FRAC_BITS{1'b0}}};
		lph_nx = advance(lph_q, inc_q, wrap);
		rph_nx = advance(rph_q, inc_q, wrap);

		req.addr_l = lph_q[PHASE_FRAC_BITS+TBL_AW-1:PHASE_FRAC_BITS];
		req.addr_r = rph_q[PHASE_FRAC_BITS+TBL_AW-1:PHASE_FRAC_BITS];
		req.amp    = (func == FUNC_TICK) ? amp_tick : amp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q    <= PHASE_W'(65536);
			size_q   <= SIZE_W'(1024);
			target_q <= UNITY_AMP;
			mute_q   <= 1'b0;
			step_q   <= AMP_W'(33);
			rstart_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PHASE_INC:   inc_q    <= cfg_wdata[PHASE_W-1:0];
				REG_TABLE_SIZE:  size_q   <= cfg_wdata[SIZE_W-1:0];
				REG_TARGET_AMP:  target_q <= cfg_wdata[AMP_W-1:0];
				REG_MUTE:        mute_q   <= cfg_wdata[0];
				REG_RAMP_STEP:   step_q   <= cfg_wdata[AMP_W-1:0];
				REG_RIGHT_START: rstart_q <= cfg_wdata[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lph_q <= '0;
			rph_q <= '0;
			amp_q <= '0;
		end else if (accept) begin
			case (func)
				FUNC_TICK: begin
					amp_q <= amp_tick;
					lph_q <= lph_nx;
					rph_q <= rph_nx;
				end
				FUNC_RESTART: begin
					lph_q <= '0;
					rph_q <= rstart_q;
				end
				default: ;
			endcase
		end
	end

	// The ramp never leaves the unity range.
	a_amp_range: assert property (@(posedge clk) disable iff (!arst_n)
		amp_q <= UNITY_AMP)
		else $error("amplitude above unity");

	// A muted tick never raises the amplitude.
	a_mute_down: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FUNC_TICK && mute_q |=> amp_q <= $past(amp_q))
		else $error("amplitude rose while muted");

	// A restart puts the left phase at zero and the right phase at its start value.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FUNC_RESTART |=> lph_q == '0 && rph_q == $past(rstart_q))
		else $error("restart did not reload the phases");

endmodule

`default_nettype wire

FILE: hw/rtl/wtor_scale.sv
// One channel's scaling multiplier: table entry times amplitude, registered.
// Depends on wtor_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtor_scale
	import wtor_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [ENTRY_W-1:0]        entry,
	input  wire logic [AMP_W-1:0]          amp,
	output      logic signed [PROD_W-1:0]  prod_s2
);

	logic signed [PROD_W-1:0] prod;

	assign prod = PROD_W'($signed(entry)) * $signed({1'b0, amp});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod;
		end
	end

endmodule

`default_nettype wire
